// ----- sv/julia_set_pixel_membership_macros.svh -----
// Assertion helpers for the block's core module.
// Each expects clk and rst_n in scope.
`ifndef JULIA_SET_PIXEL_MEMBERSHIP_MACROS_SVH
`define JULIA_SET_PIXEL_MEMBERSHIP_MACROS_SVH

// Same-cycle implication
`define JSPM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define JSPM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/jspm_pkg.sv -----
package jspm_pkg;

  localparam int MAX_ITER_DEF   = 100;
  localparam int COORD_BITS_DEF = 12;

  localparam int PIX_W     = 12;
  localparam int DATA_W    = 32;
  localparam int ADDR_W    = 5;
  localparam int PROD_W    = 64;
  localparam int FRAC_BITS = 24;

  // Plane configuration handed from the register file to the core
  typedef struct packed {
    logic signed [DATA_W-1:0] c_real;
    logic signed [DATA_W-1:0] c_imag;
    logic signed [DATA_W-1:0] real_origin;
    logic signed [DATA_W-1:0] imag_origin;
    logic signed [DATA_W-1:0] real_step;
    logic signed [DATA_W-1:0] imag_step;
  } jspm_cfg_t;

  localparam logic signed [PROD_W-1:0] SAT_MAX = 64'sd2147483647;
  localparam logic signed [PROD_W-1:0] SAT_MIN = -64'sd2147483648;

  // Clamp a wide signed value to the Q8.24 word range
  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
    logic signed [DATA_W-1:0] res;
    if (v > SAT_MAX) begin
      res = 32'sh7FFF_FFFF;
    end else if (v < SAT_MIN) begin
      res = 32'sh8000_0000;
    end else begin
      res = $signed(v[DATA_W-1:0]);
    end
    return res;
  endfunction

endpackage

// ----- sv/jspm_cfg.sv -----
module jspm_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [jspm_pkg::ADDR_W-1:0]   paddr,
  input  logic [jspm_pkg::DATA_W-1:0]   pwdata,
  output logic [jspm_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output jspm_pkg::jspm_cfg_t           cfg
);

  localparam int IDX_W = jspm_pkg::ADDR_W - 2;

  localparam logic [IDX_W-1:0] REG_C_REAL      = 3'd0;
  localparam logic [IDX_W-1:0] REG_C_IMAG      = 3'd1;
  localparam logic [IDX_W-1:0] REG_REAL_ORIGIN = 3'd2;
  localparam logic [IDX_W-1:0] REG_IMAG_ORIGIN = 3'd3;
  localparam logic [IDX_W-1:0] REG_REAL_STEP   = 3'd4;
  localparam logic [IDX_W-1:0] REG_IMAG_STEP   = 3'd5;

  jspm_pkg::jspm_cfg_t cfg_r;
  jspm_pkg::jspm_cfg_t cfg_nxt;
  logic [IDX_W-1:0]    idx;
  logic                wr_en;

  assign idx    = paddr[jspm_pkg::ADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  // Decode a write transfer; unknown indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_C_REAL:      cfg_nxt.c_real      = $signed(pwdata);
        REG_C_IMAG:      cfg_nxt.c_imag      = $signed(pwdata);
        REG_REAL_ORIGIN: cfg_nxt.real_origin = $signed(pwdata);
        REG_IMAG_ORIGIN: cfg_nxt.imag_origin = $signed(pwdata);
        REG_REAL_STEP:   cfg_nxt.real_step   = $signed(pwdata);
        REG_IMAG_STEP:   cfg_nxt.imag_step   = $signed(pwdata);
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (idx)
      REG_C_REAL:      prdata = cfg_r.c_real;
      REG_C_IMAG:      prdata = cfg_r.c_imag;
      REG_REAL_ORIGIN: prdata = cfg_r.real_origin;
      REG_IMAG_ORIGIN: prdata = cfg_r.imag_origin;
      REG_REAL_STEP:   prdata = cfg_r.real_step;
      REG_IMAG_STEP:   prdata = cfg_r.imag_step;
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ----- sv/jspm_mul.sv -----
module jspm_mul (
  input  logic                               clk,
  input  logic signed [jspm_pkg::DATA_W-1:0] mul_a,
  input  logic signed [jspm_pkg::DATA_W-1:0] mul_b,
  output logic signed [jspm_pkg::PROD_W-1:0] mul_p_r
);

  // Registered signed 32x32 product, exact in 64 bits
  always_ff @(posedge clk) begin
    mul_p_r <= jspm_pkg::PROD_W'(mul_a) * jspm_pkg::PROD_W'(mul_b);
  end

endmodule

// ----- sv/jspm_core.sv -----
`include "julia_set_pixel_membership_macros.svh"

module jspm_core #(
  parameter int MAX_ITER   = jspm_pkg::MAX_ITER_DEF,
  parameter int COORD_BITS = jspm_pkg::COORD_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic [jspm_pkg::PIX_W-1:0]         in_pixel_col,
  input  logic [jspm_pkg::PIX_W-1:0]         in_pixel_row,
  input  jspm_pkg::jspm_cfg_t                cfg,
  output logic                               busy,
  output logic                               out_strobe,
  output logic [jspm_pkg::PIX_W-1:0]         out_col,
  output logic [jspm_pkg::PIX_W-1:0]         out_row,
  output logic                               out_inside_res,
  output logic signed [jspm_pkg::DATA_W-1:0] mul_a,
  output logic signed [jspm_pkg::DATA_W-1:0] mul_b,
  input  logic signed [jspm_pkg::PROD_W-1:0] mul_p
);

  localparam int PIX_W  = jspm_pkg::PIX_W;
  localparam int DATA_W = jspm_pkg::DATA_W;
  localparam int PROD_W = jspm_pkg::PROD_W;
  localparam int FRAC   = jspm_pkg::FRAC_BITS;
  localparam int CNT_W  = $clog2(MAX_ITER + 1);
  localparam int SQ_W   = 40;  // truncated square of a Q8.24 word
  localparam int SUM_W  = 42;  // update sums before clamping
  localparam int ESC_W  = 41;  // |z|^2 sum

  localparam logic [PIX_W-1:0] COL_MASK =
    (COORD_BITS >= PIX_W) ? {PIX_W{1'b1}} : PIX_W'((1 << COORD_BITS) - 1);
  localparam logic signed [ESC_W-1:0] ESC_LIMIT = ESC_W'(64'sd4 <<< FRAC);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MAPR = 3'd1;
  localparam logic [2:0] S_MAPI = 3'd2;
  localparam logic [2:0] S_LDI  = 3'd3;
  localparam logic [2:0] S_SQX  = 3'd4;
  localparam logic [2:0] S_SQY  = 3'd5;
  localparam logic [2:0] S_XY   = 3'd6;
  localparam logic [2:0] S_UPD  = 3'd7;

  logic [2:0]               state_r, state_nxt;
  logic [CNT_W-1:0]         iter_r, iter_nxt;
  logic                     out_strobe_r, out_strobe_nxt;
  logic [PIX_W-1:0]         col_r, col_nxt;
  logic [PIX_W-1:0]         row_r, row_nxt;
  logic signed [DATA_W-1:0] zr_r, zr_nxt;
  logic signed [DATA_W-1:0] zi_r, zi_nxt;
  logic signed [SQ_W-1:0]   xx_r, xx_nxt;
  logic signed [SQ_W-1:0]   yy_r, yy_nxt;
  logic [PIX_W-1:0]         out_col_r, out_col_nxt;
  logic [PIX_W-1:0]         out_row_r, out_row_nxt;
  logic                     inside_r, inside_nxt;

  logic signed [PROD_W-1:0] p_sh;
  logic signed [PROD_W-1:0] p_sh_x2;
  logic signed [SQ_W-1:0]   sq_now;
  logic signed [SUM_W-1:0]  re_sum;
  logic signed [SUM_W-1:0]  im_sum;
  logic signed [ESC_W-1:0]  esc_sum;

  // Floor-shifted views of the shared product
  assign p_sh    = mul_p >>> FRAC;
  assign p_sh_x2 = mul_p >>> (FRAC - 1);
  assign sq_now  = $signed(p_sh[SQ_W-1:0]);
  assign re_sum  = SUM_W'(xx_r) - SUM_W'(yy_r) + SUM_W'($signed(cfg.c_real));
  assign im_sum  = SUM_W'(p_sh_x2) + SUM_W'($signed(cfg.c_imag));
  assign esc_sum = ESC_W'(xx_r) + ESC_W'(sq_now);

  assign busy           = (state_r != S_IDLE);
  assign out_strobe     = out_strobe_r;
  assign out_col        = out_col_r;
  assign out_row        = out_row_r;
  assign out_inside_res = inside_r;

  // Sequence the shared multiplier through mapping, squares and cross term
  always_comb begin
    state_nxt      = state_r;
    iter_nxt       = iter_r;
    out_strobe_nxt = 1'b0;
    col_nxt        = col_r;
    row_nxt        = row_r;
    zr_nxt         = zr_r;
    zi_nxt         = zi_r;
    xx_nxt         = xx_r;
    yy_nxt         = yy_r;
    out_col_nxt    = out_col_r;
    out_row_nxt    = out_row_r;
    inside_nxt     = inside_r;
    mul_a          = zr_r;
    mul_b          = zr_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          col_nxt   = in_pixel_col & COL_MASK;
          row_nxt   = in_pixel_row & COL_MASK;
          iter_nxt  = '0;
          state_nxt = S_MAPR;
        end
      end
      S_MAPR: begin
        mul_a     = $signed({{(DATA_W - PIX_W){1'b0}}, col_r});
        mul_b     = cfg.real_step;
        state_nxt = S_MAPI;
      end
      S_MAPI: begin
        zr_nxt    = jspm_pkg::sat32(mul_p + PROD_W'($signed(cfg.real_origin)));
        mul_a     = $signed({{(DATA_W - PIX_W){1'b0}}, row_r});
        mul_b     = cfg.imag_step;
        state_nxt = S_LDI;
      end
      S_LDI: begin
        zi_nxt    = jspm_pkg::sat32(mul_p + PROD_W'($signed(cfg.imag_origin)));
        state_nxt = S_SQX;
      end
      S_SQX: begin
        mul_a     = zr_r;
        mul_b     = zr_r;
        state_nxt = S_SQY;
      end
      S_SQY: begin
        xx_nxt    = sq_now;
        mul_a     = zi_r;
        mul_b     = zi_r;
        state_nxt = S_XY;
      end
      S_XY: begin
        yy_nxt = sq_now;
        mul_a  = zr_r;
        mul_b  = zi_r;
        // Escape is tested only after an update
        if ((iter_r != '0) && (esc_sum > ESC_LIMIT)) begin
          out_strobe_nxt = 1'b1;
          out_col_nxt    = col_r;
          out_row_nxt    = row_r;
          inside_nxt     = 1'b0;
          state_nxt      = S_IDLE;
        end else if (iter_r == CNT_W'(MAX_ITER)) begin
          out_strobe_nxt = 1'b1;
          out_col_nxt    = col_r;
          out_row_nxt    = row_r;
          inside_nxt     = 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        zr_nxt    = jspm_pkg::sat32(PROD_W'(re_sum));
        zi_nxt    = jspm_pkg::sat32(PROD_W'(im_sum));
        iter_nxt  = iter_r + CNT_W'(1);
        state_nxt = S_SQX;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      iter_r       <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      iter_r       <= iter_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  // Datapath and result payload
  always_ff @(posedge clk) begin
    col_r     <= col_nxt;
    row_r     <= row_nxt;
    zr_r      <= zr_nxt;
    zi_r      <= zi_nxt;
    xx_r      <= xx_nxt;
    yy_r      <= yy_nxt;
    out_col_r <= out_col_nxt;
    out_row_r <= out_row_nxt;
    inside_r  <= inside_nxt;
  end

  `JSPM_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted pixel did not raise busy")
  `JSPM_ASSERT_NEXT(a_strobe_pulse, out_strobe_r, !out_strobe_r, "result strobe held too long")
  `JSPM_ASSERT_NOW(a_strobe_after_work, out_strobe_r, !busy && $past(busy), "result without work")
  `JSPM_ASSERT_NOW(a_iter_bound, busy, iter_r <= CNT_W'(MAX_ITER), "iteration count overrun")

endmodule

// ----- sv/julia_set_pixel_membership.sv -----
// Channel   Direction  Ports                                       Transfer
// input     in         start, busy, in_pixel_col, in_pixel_row     start && !busy
// result    out        out_strobe, out_col, out_row, out_inside_res out_strobe, one cycle
// config    in/out     psel, penable, pwrite, paddr, pwdata, prdata psel&penable&pwrite
//
// A pixel is mapped into the plane, then iterated until it escapes or until
// MAX_ITER iterations (100 by default) have run; each iteration issues three
// products on the single shared 32x32 multiplier and one update step.
// The result strobe is high in the first cycle with busy low; a new pixel may
// be started in that same cycle. Reset is synchronous, active low, and clears
// the plane registers and the sequencer. The receiver cannot stall.
module julia_set_pixel_membership #(
  parameter int MAX_ITER   = jspm_pkg::MAX_ITER_DEF,
  parameter int COORD_BITS = jspm_pkg::COORD_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [jspm_pkg::PIX_W-1:0]  in_pixel_col,
  input  logic [jspm_pkg::PIX_W-1:0]  in_pixel_row,
  output logic                        out_strobe,
  output logic [jspm_pkg::PIX_W-1:0]  out_col,
  output logic [jspm_pkg::PIX_W-1:0]  out_row,
  output logic                        out_inside_res,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [jspm_pkg::ADDR_W-1:0] paddr,
  input  logic [jspm_pkg::DATA_W-1:0] pwdata,
  output logic [jspm_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);

  jspm_pkg::jspm_cfg_t                cfg;
  logic signed [jspm_pkg::DATA_W-1:0] mul_a;
  logic signed [jspm_pkg::DATA_W-1:0] mul_b;
  logic signed [jspm_pkg::PROD_W-1:0] mul_p;

  jspm_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  jspm_mul u_mul (
    .clk     (clk),
    .mul_a   (mul_a),
    .mul_b   (mul_b),
    .mul_p_r (mul_p)
  );

  jspm_core #(
    .MAX_ITER   (MAX_ITER),
    .COORD_BITS (COORD_BITS)
  ) u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .in_pixel_col   (in_pixel_col),
    .in_pixel_row   (in_pixel_row),
    .cfg            (cfg),
    .busy           (busy),
    .out_strobe     (out_strobe),
    .out_col        (out_col),
    .out_row        (out_row),
    .out_inside_res (out_inside_res),
    .mul_a          (mul_a),
    .mul_b          (mul_b),
    .mul_p          (mul_p)
  );

endmodule

// ----- tb/tb.sv -----
module tb;

  localparam int PIX_W     = jspm_pkg::PIX_W;
  localparam int DATA_W    = jspm_pkg::DATA_W;
  localparam int ADDR_W    = jspm_pkg::ADDR_W;
  localparam int FRAC_BITS = jspm_pkg::FRAC_BITS;

  localparam int ITER_LIMIT     = 100;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 6 + 4 * ITER_LIMIT + 20;

  localparam longint ESCAPE_BOUND = longint'(4) <<< FRAC_BITS;
  localparam int     Q824_MAX     = 32'sh7FFF_FFFF;
  localparam int     Q824_MIN     = 32'sh8000_0000;
  localparam int     Q824_ONE     = 32'sd16777216;

  typedef enum int {
    REG_C_REAL      = 0,
    REG_C_IMAG      = 1,
    REG_REAL_ORIGIN = 2,
    REG_IMAG_ORIGIN = 3,
    REG_REAL_STEP   = 4,
    REG_IMAG_STEP   = 5,
    REG_SPARE_A     = 6,
    REG_SPARE_B     = 7
  } reg_index_t;

  localparam int REG_COUNT = 6;

  typedef struct {
    logic [PIX_W-1:0] col;
    logic [PIX_W-1:0] row;
    logic             in_set;
  } pixel_result_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [PIX_W-1:0]  in_pixel_col = '0;
  logic [PIX_W-1:0]  in_pixel_row = '0;
  logic              out_strobe;
  logic [PIX_W-1:0]  out_col;
  logic [PIX_W-1:0]  out_row;
  logic              out_inside_res;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  // Shadow copy of the plane registers
  int            plane_regs [REG_COUNT] = '{default: 0};
  pixel_result_t pending_pixels [$];
  pixel_result_t oldest;
  int            n_fail = 0;
  int            idle_cycles = 0;
  bit            steady_feed = 1'b0;

  julia_set_pixel_membership #(
    .MAX_ITER   (ITER_LIMIT),
    .COORD_BITS (PIX_W)
  ) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_pixel_col   (in_pixel_col),
    .in_pixel_row   (in_pixel_row),
    .out_strobe     (out_strobe),
    .out_col        (out_col),
    .out_row        (out_row),
    .out_inside_res (out_inside_res),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Clamp to the Q8.24 word range
  function automatic longint clamp_q824(longint v);
    if (v > longint'(Q824_MAX)) return longint'(Q824_MAX);
    if (v < longint'(Q824_MIN)) return longint'(Q824_MIN);
    return v;
  endfunction

  // Map the pixel into the plane and run the escape-time iteration
  function automatic logic pixel_inside(logic [PIX_W-1:0] col, logic [PIX_W-1:0] row);
    longint col_l, row_l, zr, zi, sq_r, sq_i, xy2;
    col_l = longint'(col);
    row_l = longint'(row);
    zr = clamp_q824(longint'(plane_regs[REG_REAL_ORIGIN])
                    + col_l * longint'(plane_regs[REG_REAL_STEP]));
    zi = clamp_q824(longint'(plane_regs[REG_IMAG_ORIGIN])
                    + row_l * longint'(plane_regs[REG_IMAG_STEP]));
    sq_r = (zr * zr) >>> FRAC_BITS;
    sq_i = (zi * zi) >>> FRAC_BITS;
    for (int i = 0; i < ITER_LIMIT; i++) begin
      xy2 = (zr * zi) >>> (FRAC_BITS - 1);
      zr = clamp_q824(sq_r - sq_i + longint'(plane_regs[REG_C_REAL]));
      zi = clamp_q824(xy2 + longint'(plane_regs[REG_C_IMAG]));
      sq_r = (zr * zr) >>> FRAC_BITS;
      sq_i = (zi * zi) >>> FRAC_BITS;
      if (sq_r + sq_i > ESCAPE_BOUND) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99, 0);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  // Offer one pixel, hold until the transfer, record the expected outcome
  task automatic send_pixel(input logic [PIX_W-1:0] col, input logic [PIX_W-1:0] row);
    pixel_result_t item;
    int gap;
    start <= 1'b1;
    in_pixel_col <= col;
    in_pixel_row <= row;
    @(posedge clk);
    while (busy) @(posedge clk);
    item.col = col;
    item.row = row;
    item.in_set = pixel_inside(col, row);
    pending_pixels.push_back(item);
    gap = steady_feed ? 0 : pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop start and wait for every pending pixel to come back
  task automatic drain_pixels();
    start <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // One transfer on the register port: a setup phase, then an access phase
  task automatic bus_cycle(input logic is_write, input int idx, input int value,
                           output logic [DATA_W-1:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= is_write;
    paddr <= ADDR_W'(idx * 4);
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_reg(input int idx, input int value);
    logic [DATA_W-1:0] unused;
    bus_cycle(1'b1, idx, value, unused);
    if (idx < REG_COUNT) plane_regs[idx] = value;
  endtask

  task automatic check_reg(input int idx);
    logic [DATA_W-1:0] rdata;
    reg_index_t ri;
    ri = reg_index_t'(idx);
    bus_cycle(1'b0, idx, 0, rdata);
    if (rdata !== plane_regs[idx]) begin
      $error("%s: expected %h, actual %h", ri.name(), plane_regs[idx], rdata);
      n_fail++;
    end
  endtask

  task automatic load_plane(input int c_re, input int c_im, input int re_org,
                            input int im_org, input int re_stp, input int im_stp);
    write_reg(REG_C_REAL, c_re);
    write_reg(REG_C_IMAG, c_im);
    write_reg(REG_REAL_ORIGIN, re_org);
    write_reg(REG_IMAG_ORIGIN, im_org);
    write_reg(REG_REAL_STEP, re_stp);
    write_reg(REG_IMAG_STEP, im_stp);
  endtask

  // Random c near the set, view centered on the origin
  task automatic load_random_view();
    int c_re, c_im, re_stp, im_stp;
    c_re = $urandom_range(2 * Q824_ONE, 0);
    c_re = c_re - Q824_ONE;
    c_im = $urandom_range(2 * Q824_ONE, 0);
    c_im = c_im - Q824_ONE;
    re_stp = $urandom_range(16384, 2048);
    im_stp = $urandom_range(16384, 2048);
    if ($urandom_range(3, 0) == 0) re_stp = -re_stp;
    if ($urandom_range(3, 0) == 0) im_stp = -im_stp;
    load_plane(c_re, c_im, -re_stp * 2048, -im_stp * 2048, re_stp, im_stp);
  endtask

  // Reset values: every pixel maps to zero with c zero
  task automatic test_reset_defaults();
    for (int i = 0; i < REG_COUNT; i++) check_reg(i);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'hFFF, 12'hFFF);
    send_pixel(12'd0, 12'hFFF);
    send_pixel(12'hFFF, 12'd0);
    drain_pixels();
  endtask

  // Write and read back each register; writes past the last index are ignored
  task automatic test_register_access();
    for (int i = 0; i < REG_COUNT; i++) begin
      write_reg(i, $urandom());
      check_reg(i);
    end
    write_reg(REG_SPARE_A, $urandom());
    write_reg(REG_SPARE_B, $urandom());
    for (int i = 0; i < REG_COUNT; i++) check_reg(i);
  endtask

  task automatic test_directed_points();
    // Coarse classic view: the far corner saturates the real part of the mapping
    load_plane(-13421773, 2617246, -25165824, -16777216, 786432, 524288);
    send_pixel(12'd32, 12'd32);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd63, 12'd63);
    send_pixel(12'hFFF, 12'hFFF);
    send_pixel(12'hFFF, 12'd0);
    send_pixel(12'd0, 12'hFFF);
    drain_pixels();
    // Mapping saturates high
    load_plane(0, 0, Q824_MAX, Q824_MAX, Q824_MAX, Q824_MAX);
    send_pixel(12'hFFF, 12'hFFF);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd1, 12'd0);
    drain_pixels();
    // Mapping saturates low
    load_plane(0, 0, Q824_MIN, Q824_MIN, Q824_MIN, Q824_MIN);
    send_pixel(12'hFFF, 12'hFFF);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd0, 12'd1);
    drain_pixels();
    // Iterate saturates through c
    load_plane(Q824_MAX, Q824_MIN, 0, 0, 0, 0);
    send_pixel(12'd0, 12'd0);
    drain_pixels();
    load_plane(Q824_MIN, Q824_MAX, 0, 0, 0, 0);
    send_pixel(12'd2048, 12'd2048);
    drain_pixels();
    // Iterate saturates through a huge square
    load_plane(0, 0, Q824_MAX, Q824_MIN, 0, 0);
    send_pixel(12'd5, 12'd7);
    drain_pixels();
  endtask

  // Views that spread the full pixel range over the interesting region
  task automatic test_random_views();
    for (int phase = 0; phase < 6; phase++) begin
      if (phase == 0) load_plane(-13421773, 2617246, -25165824, -16777216, 12288, 8192);
      else load_random_view();
      steady_feed = (phase % 3 == 2);
      repeat (60) send_pixel(PIX_W'($urandom()), PIX_W'($urandom()));
      drain_pixels();
    end
    steady_feed = 1'b0;
  endtask

  // Fully random register contents
  task automatic test_wild_registers();
    repeat (2) begin
      load_plane($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
      repeat (35) send_pixel(PIX_W'($urandom()), PIX_W'($urandom()));
      drain_pixels();
    end
  endtask

  // Compare each result with the oldest pending pixel
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (pending_pixels.size() == 0) begin
        $error("out_strobe: no pixel pending, actual col %0d row %0d", out_col, out_row);
        n_fail++;
      end else begin
        oldest = pending_pixels.pop_front();
        if (out_col !== oldest.col) begin
          $error("out_col: expected %0d, actual %0d", oldest.col, out_col);
          n_fail++;
        end
        if (out_row !== oldest.row) begin
          $error("out_row: expected %0d, actual %0d", oldest.row, out_row);
          n_fail++;
        end
        if (out_inside_res !== oldest.in_set) begin
          $error("out_inside_res: expected %0d, actual %0d", oldest.in_set, out_inside_res);
          n_fail++;
        end
      end
    end
  end

  // Count cycles with no transfer on any port
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe || (psel && penable)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("julia_set_pixel_membership test failed");
        $finish;
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_register_access();
    test_directed_points();
    test_random_views();
    test_wild_registers();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (n_fail == 0) begin
      $display("julia_set_pixel_membership test passed");
    end else begin
      $display("julia_set_pixel_membership test failed");
    end
    $finish;
  end

endmodule
